>>> rtl/todpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// todpt_pkg
// Shared widths, register indexes and controller/datapath command types.
// ----------------------------------------------------------------------------
package todpt_pkg;

  localparam int TENTHS_W  = 4;
  localparam int SECONDS_W = 6;
  localparam int MINUTES_W = 6;
  localparam int HOURS_W   = 5;

  localparam int SEC_PER_W = 12;
  localparam int MIN_PER_W = 11;

  // remainder unit: one quotient bit per step
  localparam int DIV_W     = 12;
  localparam int DIV_STEPS = DIV_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_SECOND_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MINUTE_PERIOD = 2'd1;

  typedef struct packed {
    logic tick;    // beat taken on the input side
    logic load;    // load dividends, clear remainders
    logic step;    // one remainder step
    logic finish;  // update one-shots, load output register
  } todpt_cmd_t;

  typedef struct packed {
    logic out_busy;
  } todpt_stat_t;

endpackage

>>> rtl/todpt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// todpt interfaces
// Tick input, time output and configuration write channels.
// ----------------------------------------------------------------------------
interface todpt_tick_if;
  logic valid;
  logic ready;
  logic advance;
  modport source (output valid, output advance, input ready);
  modport sink   (input valid, input advance, output ready);
endinterface

interface todpt_time_if;
  logic       valid;
  logic       ready;
  logic [3:0] tenths;
  logic [5:0] seconds;
  logic [5:0] minutes;
  logic [4:0] hours;
  logic       second_fire;
  logic       minute_fire;
  modport source (output valid, output tenths, output seconds, output minutes,
                  output hours, output second_fire, output minute_fire, input ready);
  modport sink   (input valid, input tenths, input seconds, input minutes,
                  input hours, input second_fire, input minute_fire, output ready);
endinterface

interface todpt_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [11:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/time_of_day_periodic_trigger_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_of_day_periodic_trigger_core
// 24-hour clock in ticks, seconds, minutes, hours with two periodic triggers.
// Sequence: accept the input beat, load the dividends, run the 12-step restoring
// remainder units (one quotient bit per cycle), then load the output register
// once it is free. A new beat is taken only after that hand-off.
// Reset (synchronous): time cleared, both triggers armed, periods set to 1.
// Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module time_of_day_periodic_trigger_core
  import todpt_pkg::*;
#(
  parameter int TICKS_PER_SECOND = 10
) (
  input  logic  clk,
  input  logic  rst,
  todpt_tick_if.sink   tick_ch,
  todpt_time_if.source time_ch,
  todpt_cfg_if.sink    cfg_ch
);

  todpt_cmd_t  cmd;
  todpt_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  todpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tick_ch.valid),
    .in_ready (tick_ch.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  todpt_dp #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .advance     (tick_ch.advance),
    .cfg_we      (cfg_ch.valid),
    .cfg_index   (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .out_valid   (time_ch.valid),
    .out_ready   (time_ch.ready),
    .tenths      (time_ch.tenths),
    .seconds     (time_ch.seconds),
    .minutes     (time_ch.minutes),
    .hours       (time_ch.hours),
    .second_fire (time_ch.second_fire),
    .minute_fire (time_ch.minute_fire)
  );

endmodule

>>> rtl/todpt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// todpt_ctrl
// Sequencer: take a tick beat, run the remainder unit, hand off the result.
// ----------------------------------------------------------------------------
module todpt_ctrl
  import todpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output todpt_cmd_t  cmd,
  input  todpt_stat_t stat
);

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_DIV, S_DONE} state_t;

  state_t              state;
  logic [STEP_W-1:0]   step_cnt;
  logic                ready;

  assign in_ready = ready;

  always_comb begin
    cmd        = '0;
    cmd.tick   = ready && in_valid;
    cmd.load   = (state == S_LOAD);
    cmd.step   = (state == S_DIV);
    cmd.finish = (state == S_DONE) && !stat.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step_cnt <= '0;
      ready    <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ready && in_valid) begin
            ready <= 1'b0;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          step_cnt <= '0;
          state    <= S_DIV;
        end
        S_DIV: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == STEP_W'(DIV_STEPS - 1)) state <= S_DONE;
        end
        S_DONE: begin
          if (!stat.out_busy) begin
            ready <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/todpt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// todpt_dp
// Time counters, period registers, restoring remainder units, one-shots and
// output register.
// ----------------------------------------------------------------------------
module todpt_dp
  import todpt_pkg::*;
#(
  parameter int TICKS_PER_SECOND = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  todpt_cmd_t              cmd,
  output todpt_stat_t             stat,
  input  logic                    advance,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [TENTHS_W-1:0]     tenths,
  output logic [SECONDS_W-1:0]    seconds,
  output logic [MINUTES_W-1:0]    minutes,
  output logic [HOURS_W-1:0]      hours,
  output logic                    second_fire,
  output logic                    minute_fire
);

  localparam int TW = (TICKS_PER_SECOND > 2) ? $clog2(TICKS_PER_SECOND) : 1;

  logic [TW-1:0]          tenth_count;
  logic [SECONDS_W-1:0]   second_count;
  logic [MINUTES_W-1:0]   minute_count;
  logic [HOURS_W-1:0]     hour_count;
  logic                   second_done;
  logic                   minute_done;
  logic [SEC_PER_W-1:0]   second_period;
  logic [MIN_PER_W-1:0]   minute_period;

  logic [DIV_W-1:0]       sec_quo;
  logic [DIV_W-1:0]       sec_rem;
  logic [DIV_W-1:0]       min_quo;
  logic [DIV_W-1:0]       min_rem;
  logic [DIV_W-1:0]       sec_val;
  logic [DIV_W-1:0]       min_val;
  logic [DIV_W-1:0]       sec_div;
  logic [DIV_W-1:0]       min_div;
  logic                   sec_cond;
  logic                   min_cond;
  logic [TW+TENTHS_W-1:0] tenth_ext;

  function automatic logic [DIV_W-1:0] rem_step(input logic [DIV_W-1:0] rem,
                                                input logic             b,
                                                input logic [DIV_W-1:0] p);
    logic [DIV_W:0] t;
    t = {rem, b};
    if (t >= {1'b0, p}) return DIV_W'(t - {1'b0, p});
    return DIV_W'(t);
  endfunction

  // x*60 as x*64 - x*4
  assign sec_val = DIV_W'(second_count) + (DIV_W'(minute_count) << 6)
                 - (DIV_W'(minute_count) << 2);
  assign min_val = DIV_W'(minute_count) + (DIV_W'(hour_count) << 6)
                 - (DIV_W'(hour_count) << 2);
  assign sec_div = DIV_W'(second_period);
  assign min_div = DIV_W'(minute_period);

  assign sec_cond = (second_period != '0) && (sec_rem == '0);
  assign min_cond = (minute_period != '0) && (min_rem == '0);

  assign stat.out_busy = out_valid && !out_ready;

  assign tenth_ext = {{TENTHS_W{1'b0}}, tenth_count};

  // time of day
  always_ff @(posedge clk) begin
    if (rst) begin
      tenth_count  <= '0;
      second_count <= '0;
      minute_count <= '0;
      hour_count   <= '0;
    end else if (cmd.tick && advance) begin
      if (tenth_count == TW'(TICKS_PER_SECOND - 1)) begin
        tenth_count <= '0;
        if (second_count == SECONDS_W'(59)) begin
          second_count <= '0;
          if (minute_count == MINUTES_W'(59)) begin
            minute_count <= '0;
            if (hour_count == HOURS_W'(23)) hour_count <= '0;
            else                            hour_count <= hour_count + 1'b1;
          end else begin
            minute_count <= minute_count + 1'b1;
          end
        end else begin
          second_count <= second_count + 1'b1;
        end
      end else begin
        tenth_count <= tenth_count + 1'b1;
      end
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      second_period <= SEC_PER_W'(1);
      minute_period <= MIN_PER_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SECOND_PERIOD: second_period <= cfg_data[SEC_PER_W-1:0];
        REG_MINUTE_PERIOD: minute_period <= cfg_data[MIN_PER_W-1:0];
        default: ;
      endcase
    end
  end

  // remainder units
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sec_quo <= sec_val;
      min_quo <= min_val;
      sec_rem <= '0;
      min_rem <= '0;
    end else if (cmd.step) begin
      sec_quo <= sec_quo << 1;
      min_quo <= min_quo << 1;
      sec_rem <= rem_step(sec_rem, sec_quo[DIV_W-1], sec_div);
      min_rem <= rem_step(min_rem, min_quo[DIV_W-1], min_div);
    end
  end

  // one-shots: re-arm when the condition drops
  always_ff @(posedge clk) begin
    if (rst) begin
      second_done <= 1'b0;
      minute_done <= 1'b0;
    end else if (cmd.finish) begin
      second_done <= sec_cond;
      minute_done <= min_cond;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      tenths      <= tenth_ext[TENTHS_W-1:0];
      seconds     <= second_count;
      minutes     <= minute_count;
      hours       <= hour_count;
      second_fire <= sec_cond && !second_done;
      minute_fire <= min_cond && !minute_done;
    end
  end

endmodule

>>> rtl/todpt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// todpt_checker
// Port-level checks on the trigger core, bound to the top level.
// ----------------------------------------------------------------------------
module todpt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] seconds,
  input logic [5:0] minutes,
  input logic [4:0] hours,
  input logic       second_fire,
  input logic       minute_fire
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before taken");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(seconds) && $stable(minutes) && $stable(hours)
                                && $stable(second_fire) && $stable(minute_fire))
    else $error("stalled result changed");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> seconds <= 6'd59 && minutes <= 6'd59 && hours <= 5'd23)
    else $error("time field out of range");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second tick beat taken while busy");

endmodule

bind time_of_day_periodic_trigger_core todpt_checker u_todpt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (tick_ch.valid),
  .in_ready    (tick_ch.ready),
  .out_valid   (time_ch.valid),
  .out_ready   (time_ch.ready),
  .seconds     (time_ch.seconds),
  .minutes     (time_ch.minutes),
  .hours       (time_ch.hours),
  .second_fire (time_ch.second_fire),
  .minute_fire (time_ch.minute_fire)
);
